### src/slipfr_pkg.sv
// Shared types and constants for the SLIP frame receiver.
`timescale 1ns / 1ps

package slipfr_pkg;

  // SLIP framing bytes
  localparam logic [7:0] END_CHAR     = 8'hC0;
  localparam logic [7:0] ESC_CHAR     = 8'hDB;
  localparam logic [7:0] ESC_END_CHAR = 8'hDC;
  localparam logic [7:0] ESC_ESC_CHAR = 8'hDD;

  // Item function codes
  localparam logic FUNC_DECODE = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Default frame store depth and reported length width
  localparam int MAX_FRAME_LEN_DEF = 256;
  localparam int LEN_W             = 9;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } in_t;

  typedef struct packed {
    logic             frame_done;
    logic [LEN_W-1:0] frame_length;
    logic [7:0]       read_data;
  } out_t;

endpackage

### src/slip_frame_receiver.sv
// SLIP frame receiver top level: decoder control, frame store and result path.
`timescale 1ns / 1ps

// Takes one item per clock cycle with no gaps while the output is not
// stalled: a decode item carries a received byte that is unescaped and
// written into the frame store, a read item fetches one stored byte. Every
// item gives one result: stage 1 waits on the registered read port of the
// frame store RAM and then moves into the output register. The frame store
// is not cleared after reset, so only bytes below the last reported frame
// length are meaningful; a read index at or above MAX_FRAME_LEN returns 0.
// A closing END of a non-empty frame reports the frame length in
// frame_done and frame_length (low 9 bits).
module slip_frame_receiver #(
  parameter int MAX_FRAME_LEN = slipfr_pkg::MAX_FRAME_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  slipfr_pkg::in_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output slipfr_pkg::out_t out_data
);

  localparam int AW = (MAX_FRAME_LEN > 1) ? $clog2(MAX_FRAME_LEN) : 1;
  localparam int CW = $clog2(MAX_FRAME_LEN + 1);
  localparam int LW = slipfr_pkg::LEN_W;
  localparam logic [CW-1:0] FULL = CW'(MAX_FRAME_LEN);

  typedef enum logic [1:0] {
    IDLE,
    MESSAGE,
    ESCAPE
  } mode_t;

  mode_t            rx_mode, rx_mode_next;
  logic [CW-1:0]    fill_count, fill_count_next;

  // stage 1: waits on RAM read data
  logic             s1_valid;
  logic             s1_read;
  logic             s1_in_range;
  logic             s1_done;
  logic [LW-1:0]    s1_length;

  logic             accept;
  logic             advance;
  logic             is_decode;
  logic             do_store;
  logic [7:0]       store_val;
  logic             wr_en;
  logic             done_c;
  logic [LW-1:0]    length_c;
  logic [CW+LW-1:0] fill_wide;
  logic [AW+7:0]    ridx_wide;
  logic [AW-1:0]    rd_addr;
  logic             rd_in_range;
  logic [7:0]       rd_data;

  // handshake
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;
  assign is_decode = (in_data.func == slipfr_pkg::FUNC_DECODE);

  // read address and range check
  assign ridx_wide   = {{AW{1'b0}}, in_data.read_index};
  assign rd_addr     = ridx_wide[AW-1:0];
  assign rd_in_range = ({{CW{1'b0}}, in_data.read_index} < (CW + 8)'(MAX_FRAME_LEN));

  // reported length is the fill count masked to the length field
  assign fill_wide = {{LW{1'b0}}, fill_count};

  // SLIP decode of one received byte
  always_comb begin
    rx_mode_next    = rx_mode;
    fill_count_next = fill_count;
    do_store        = 1'b0;
    store_val       = in_data.rx_byte;
    wr_en           = 1'b0;
    done_c          = 1'b0;
    length_c        = '0;
    if (is_decode) begin
      case (rx_mode)
        MESSAGE: begin
          if (in_data.rx_byte == slipfr_pkg::END_CHAR) begin
            if (fill_count != '0) begin
              done_c          = 1'b1;
              length_c        = fill_wide[LW-1:0];
              fill_count_next = '0;
            end
          end else if (in_data.rx_byte == slipfr_pkg::ESC_CHAR) begin
            rx_mode_next = ESCAPE;
          end else begin
            do_store = 1'b1;
          end
        end
        ESCAPE: begin
          if (in_data.rx_byte == slipfr_pkg::ESC_END_CHAR) begin
            do_store  = 1'b1;
            store_val = slipfr_pkg::END_CHAR;
          end else if (in_data.rx_byte == slipfr_pkg::ESC_ESC_CHAR) begin
            do_store  = 1'b1;
            store_val = slipfr_pkg::ESC_CHAR;
          end else if (in_data.rx_byte == slipfr_pkg::END_CHAR) begin
            fill_count_next = '0;
            rx_mode_next    = MESSAGE;
          end else begin
            rx_mode_next = IDLE;
          end
        end
        default: begin
          rx_mode_next = IDLE;
          if (in_data.rx_byte == slipfr_pkg::END_CHAR) begin
            fill_count_next = '0;
            rx_mode_next    = MESSAGE;
          end
        end
      endcase
      // store with overflow check
      if (do_store) begin
        if (fill_count != FULL) begin
          wr_en           = 1'b1;
          fill_count_next = fill_count + CW'(1);
          rx_mode_next    = MESSAGE;
        end else begin
          rx_mode_next = IDLE;
        end
      end
    end
  end

  // frame store
  slipfr_ram #(
    .WIDTH (8),
    .DEPTH (MAX_FRAME_LEN)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (fill_count[AW-1:0]),
    .wr_data (store_val),
    .rd_en   (accept && !is_decode),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state, stage 1 and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_mode    <= IDLE;
      fill_count <= '0;
      s1_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        rx_mode    <= rx_mode_next;
        fill_count <= fill_count_next;
      end
      s1_valid <= accept || (s1_valid && !advance);
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_read     <= !is_decode;
      s1_in_range <= rd_in_range;
      s1_done     <= done_c;
      s1_length   <= length_c;
    end
    if (advance) begin
      out_data.frame_done   <= s1_done;
      out_data.frame_length <= s1_length;
      out_data.read_data    <= (s1_read && s1_in_range) ? rd_data : 8'h00;
    end
  end

  // fill count never passes the store depth
  assert property (@(posedge clk) disable iff (rst) fill_count <= FULL)
    else $error("fill count beyond frame store depth");

  // a stalled stage 1 item is kept
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |=> s1_valid)
    else $error("stage 1 item lost during stall");

  // an ESC byte in a frame enters escape mode
  assert property (@(posedge clk) disable iff (rst)
    accept && is_decode && rx_mode == MESSAGE &&
    in_data.rx_byte == slipfr_pkg::ESC_CHAR |=> rx_mode == ESCAPE)
    else $error("ESC byte did not enter escape mode");

  // a reported frame is never empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.frame_length != '0 || FULL > CW'(511))
    else $error("empty frame reported");

endmodule

### src/slipfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module slipfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/slip_frame_receiver_test.sv
// Testbench for the SLIP frame receiver: directed and random byte streams checked item by item.
`timescale 1ns / 1ps
module slip_frame_receiver_test;

  localparam int FRAME_CAP      = slipfr_pkg::MAX_FRAME_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 350;

  typedef enum logic [1:0] {RX_IDLE, RX_MESSAGE, RX_ESCAPE} rx_mode_e;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  slipfr_pkg::in_t  in_data   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  slipfr_pkg::out_t out_data;

  // Decoder state mirrored by the predictor
  rx_mode_e    pred_mode    = RX_IDLE;
  int unsigned pred_fill    = 0;
  int unsigned written_span = 0;  // entries [0, written_span) have been written
  logic [7:0]  pred_store [FRAME_CAP];

  slipfr_pkg::out_t awaited_results [$];
  int unsigned items_sent   = 0;
  int unsigned failures     = 0;
  int unsigned idle_cycles  = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_left   = 0;

  slip_frame_receiver u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Mostly short idle spans, a few long ones
  function automatic int unsigned gap_length();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 80) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(40, 20);
  endfunction

  // Append one decoded byte, or drop to idle on overflow
  function automatic void store_decoded(logic [7:0] b);
    if (pred_fill < FRAME_CAP) begin
      pred_store[pred_fill] = b;
      pred_fill++;
      if (pred_fill > written_span) written_span = pred_fill;
      pred_mode = RX_MESSAGE;
    end else begin
      pred_mode = RX_IDLE;
    end
  endfunction

  // Expected result of one item; advances the decoder state
  function automatic slipfr_pkg::out_t predict_result(slipfr_pkg::in_t item);
    slipfr_pkg::out_t r;
    r = '0;
    if (item.func == slipfr_pkg::FUNC_READ) begin
      if (item.read_index < FRAME_CAP) r.read_data = pred_store[item.read_index];
    end else begin
      case (pred_mode)
        RX_MESSAGE: begin
          if (item.rx_byte == slipfr_pkg::END_CHAR) begin
            if (pred_fill != 0) begin
              r.frame_done   = 1'b1;
              r.frame_length = pred_fill[slipfr_pkg::LEN_W-1:0];
              pred_fill      = 0;
            end
          end else if (item.rx_byte == slipfr_pkg::ESC_CHAR) begin
            pred_mode = RX_ESCAPE;
          end else begin
            store_decoded(item.rx_byte);
          end
        end
        RX_ESCAPE: begin
          if (item.rx_byte == slipfr_pkg::ESC_END_CHAR) begin
            store_decoded(slipfr_pkg::END_CHAR);
          end else if (item.rx_byte == slipfr_pkg::ESC_ESC_CHAR) begin
            store_decoded(slipfr_pkg::ESC_CHAR);
          end else if (item.rx_byte == slipfr_pkg::END_CHAR) begin
            pred_fill = 0;
            pred_mode = RX_MESSAGE;
          end else begin
            pred_mode = RX_IDLE;
          end
        end
        default: begin
          if (item.rx_byte == slipfr_pkg::END_CHAR) begin
            pred_fill = 0;
            pred_mode = RX_MESSAGE;
          end else begin
            pred_mode = RX_IDLE;
          end
        end
      endcase
    end
    return r;
  endfunction

  // Result checker and receiver-side stalls
  always @(posedge clk) begin : result_check
    slipfr_pkg::out_t want;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result: done=%0d len=%0d data=%02h",
                     out_data.frame_done, out_data.frame_length, out_data.read_data);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.frame_done !== want.frame_done ||
              out_data.frame_length !== want.frame_length ||
              out_data.read_data !== want.read_data) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: exp done=%0d len=%0d data=%02h, got done=%0d len=%0d data=%02h",
                       want.frame_done, want.frame_length, want.read_data,
                       out_data.frame_done, out_data.frame_length, out_data.read_data);
          end
        end
      end
      if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(99, 0) < stall_pct) stall_left <= gap_length();
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Present one item, wait for it to be taken, then maybe idle
  task automatic send_item(slipfr_pkg::in_t item);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    awaited_results.push_back(predict_result(item));
    items_sent++;
    gap = ($urandom_range(99, 0) < gap_pct) ? gap_length() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    slipfr_pkg::in_t item;
    item.func       = slipfr_pkg::FUNC_DECODE;
    item.rx_byte    = b;
    item.read_index = 8'($urandom_range(255, 0));
    send_item(item);
  endtask

  task automatic send_read(logic [7:0] idx);
    slipfr_pkg::in_t item;
    item.func       = slipfr_pkg::FUNC_READ;
    item.rx_byte    = 8'($urandom_range(255, 0));
    item.read_index = idx;
    send_item(item);
  endtask

  // Read only entries that have been written at some point
  task automatic read_stored();
    if (written_span != 0) send_read(8'($urandom_range(written_span - 1, 0)));
  endtask

  // Payload byte with the framing bytes weighted up
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(3, 0) == 0) begin
      case ($urandom_range(3, 0))
        0:       return slipfr_pkg::END_CHAR;
        1:       return slipfr_pkg::ESC_CHAR;
        2:       return slipfr_pkg::ESC_END_CHAR;
        default: return slipfr_pkg::ESC_ESC_CHAR;
      endcase
    end
    return 8'($urandom_range(255, 0));
  endfunction

  // One payload byte, escaped as a well-behaved sender would
  task automatic put_data(logic [7:0] b);
    if (b == slipfr_pkg::END_CHAR) begin
      send_byte(slipfr_pkg::ESC_CHAR);
      send_byte(slipfr_pkg::ESC_END_CHAR);
    end else if (b == slipfr_pkg::ESC_CHAR) begin
      send_byte(slipfr_pkg::ESC_CHAR);
      send_byte(slipfr_pkg::ESC_ESC_CHAR);
    end else begin
      send_byte(b);
    end
  endtask

  // Broken framing: bad escape, END after ESC, or a stray raw byte
  task automatic inject_fault();
    logic [7:0] b;
    case ($urandom_range(2, 0))
      0: begin
        do b = 8'($urandom_range(255, 0));
        while (b == slipfr_pkg::END_CHAR || b == slipfr_pkg::ESC_END_CHAR ||
               b == slipfr_pkg::ESC_ESC_CHAR);
        send_byte(slipfr_pkg::ESC_CHAR);
        send_byte(b);
      end
      1: begin
        send_byte(slipfr_pkg::ESC_CHAR);
        send_byte(slipfr_pkg::END_CHAR);
      end
      default: send_byte(pick_byte());
    endcase
  endtask

  function automatic int unsigned random_frame_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 75) return $urandom_range(16, 1);
    if (r < 93) return $urandom_range(80, 17);
    if (r < 98) return $urandom_range(FRAME_CAP - 1, 81);
    if (r == 98) return FRAME_CAP;
    return $urandom_range(FRAME_CAP + 3, FRAME_CAP + 1);
  endfunction

  task automatic send_frame(int unsigned len, bit noisy);
    send_byte(slipfr_pkg::END_CHAR);
    if ($urandom_range(4, 0) == 0) send_byte(slipfr_pkg::END_CHAR);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9, 0) == 0) read_stored();
      if (noisy && $urandom_range(49, 0) == 0) inject_fault();
      put_data(pick_byte());
    end
    send_byte(slipfr_pkg::END_CHAR);
  endtask

  // Stop sending until every outstanding result has come back
  task automatic drain_results();
    if (awaited_results.size() != 0) begin
      in_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clk);
    end
  endtask

  // Framing corner cases with short frames
  task automatic test_directed();
    gap_pct   = 20;
    stall_pct = 20;
    // bytes in idle are ignored
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(slipfr_pkg::ESC_END_CHAR);
    // open, then a repeated END on an empty frame
    send_byte(slipfr_pkg::END_CHAR);
    send_byte(slipfr_pkg::END_CHAR);
    // both escapes and the byte extremes, closed with length 4
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(slipfr_pkg::ESC_END_CHAR);
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(slipfr_pkg::ESC_ESC_CHAR);
    send_byte(slipfr_pkg::END_CHAR);
    for (int i = 0; i < 4; i++) send_read(8'(i));
    // END after ESC drops the partial frame and restarts
    send_byte(8'h11);
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(slipfr_pkg::END_CHAR);
    send_byte(8'h22);
    send_byte(slipfr_pkg::END_CHAR);
    // bad escape goes idle; the next data byte is ignored
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(8'h12);
    send_byte(8'h33);
    send_byte(slipfr_pkg::END_CHAR);
  endtask

  // Full-length frame and both ways of overflowing the store
  task automatic test_full_frames();
    gap_pct   = 10;
    stall_pct = 10;
    send_byte(slipfr_pkg::END_CHAR);
    repeat (FRAME_CAP) put_data(pick_byte());
    send_byte(slipfr_pkg::END_CHAR);
    send_read(8'd0);
    send_read(8'(FRAME_CAP - 1));
    repeat (20) read_stored();
    drain_results();
    // plain data byte on a full store
    repeat (FRAME_CAP) put_data(pick_byte());
    send_byte(8'h5A);
    send_byte(8'h66);
    send_byte(slipfr_pkg::END_CHAR);
    // escaped byte on a full store
    repeat (FRAME_CAP) put_data(pick_byte());
    send_byte(slipfr_pkg::ESC_CHAR);
    send_byte(slipfr_pkg::ESC_END_CHAR);
    send_byte(slipfr_pkg::END_CHAR);
    repeat (10) read_stored();
  endtask

  // Full-rate traffic with no gaps and no stalls
  task automatic test_back_to_back();
    int unsigned start;
    start     = items_sent;
    gap_pct   = 0;
    stall_pct = 0;
    while (items_sent - start < 120) send_frame($urandom_range(12, 1), 1'b1);
  endtask

  function automatic int unsigned pick_pct();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  // Random frames with random content, some noise and changing pressure
  task automatic test_random_traffic(int unsigned quota);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < quota) begin
      if ($urandom_range(7, 0) == 0) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
      end
      if ($urandom_range(19, 0) == 0) drain_results();
      if ($urandom_range(9, 0) == 0) inject_fault();
      send_frame(random_frame_len(), 1'b1);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_frames();
    test_back_to_back();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();
    repeat (8) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
